// ----- rtl/tset_pkg.sv -----
// ----------------------------------------------------------------------------
// tset_pkg
// Shared types and event codes for the touch slot event tracker.
// ----------------------------------------------------------------------------
package tset_pkg;

    localparam logic [15:0] EV_TYPE_SYN = 16'h0000;
    localparam logic [15:0] EV_TYPE_ABS = 16'h0003;
    localparam logic [15:0] CODE_SLOT   = 16'h002f;
    localparam logic [15:0] CODE_TRACK  = 16'h0039;
    localparam logic [15:0] CODE_POS_X  = 16'h0035;
    localparam logic [15:0] CODE_POS_Y  = 16'h0036;
    localparam logic [15:0] CODE_REPORT = 16'h0000;

    typedef enum logic [1:0] {
        KIND_DOWN = 2'd0,
        KIND_MOVE = 2'd1,
        KIND_UP   = 2'd2
    } touch_kind_t;

    typedef struct packed {
        logic [15:0]        event_type;
        logic [15:0]        event_code;
        logic signed [31:0] event_value;
    } event_t;

    typedef struct packed {
        logic [1:0]  touch_kind;
        logic [3:0]  touch_slot;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } result_word_t;

endpackage

// ----- rtl/tset_if.sv -----
// ----------------------------------------------------------------------------
// touch_event_if / touch_result_if
// Valid/ready channels for input events and touch results.
// ----------------------------------------------------------------------------
interface touch_event_if;
    logic               valid;
    logic               ready;
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;

    modport source (output valid, output event_type, output event_code,
                    output event_value, input ready);
    modport sink   (input valid, input event_type, input event_code,
                    input event_value, output ready);
endinterface

interface touch_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  touch_kind;
    logic [3:0]  touch_slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;

    modport source (output valid, output touch_kind, output touch_slot,
                    output pos_x, output pos_y, input ready);
    modport sink   (input valid, input touch_kind, input touch_slot,
                    input pos_x, input pos_y, output ready);
endinterface

// ----- rtl/touch_slot_event_tracker.sv -----
// ----------------------------------------------------------------------------
// touch_slot_event_tracker
// Multitouch slot protocol decoder: evdev events in, touch results out.
// ----------------------------------------------------------------------------
// evt carries one evdev event per word (event_type, event_code, event_value).
// res carries touch results (touch_kind, touch_slot, pos_x, pos_y).
// slot, tracking id and position events update the current slot record;
// a report event emits at most one result for the lowest changed slot,
// other changed slots wait for later reports.
// an accepted event lands in the input register; when the result register
// is free the slot core updates its records from it and, on a report,
// loads the result register, which drives res.valid, so a result passes
// the input register and then the result register on its way out.
// throughput is one event per cycle while the result register is free.
// a stalled receiver holds the result register; the core then pauses and
// evt.ready drops once the input register is also full.
// reset clears the current slot and all slot records at once; no clearing
// pass is needed and an event can be taken as soon as reset is released.
// ----------------------------------------------------------------------------
module touch_slot_event_tracker #(
    parameter int NUM_SLOTS  = 10,
    parameter int COORD_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    touch_event_if.sink     evt,
    touch_result_if.source  res
);

    logic                   advance;
    logic                   item_valid;
    tset_pkg::event_t       item;
    logic                   res_free;
    tset_pkg::result_word_t core_res;

    tset_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tset_slot_core #(
        .NUM_SLOTS  (NUM_SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .res_free   (res_free),
        .advance    (advance),
        .res        (core_res)
    );

    tset_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_in   (core_res),
        .res_free (res_free),
        .res      (res)
    );

endmodule

// ----- rtl/tset_in_stage.sv -----
// ----------------------------------------------------------------------------
// tset_in_stage
// Input register: holds one accepted event until the slot core takes it.
// ----------------------------------------------------------------------------
module tset_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    touch_event_if.sink       evt,
    input  logic              advance,
    output logic              item_valid,
    output tset_pkg::event_t  item
);

    logic             valid_reg;
    logic             valid_next;
    tset_pkg::event_t item_reg;

    assign evt.ready  = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (evt.valid && evt.ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            item_reg.event_type  <= evt.event_type;
            item_reg.event_code  <= evt.event_code;
            item_reg.event_value <= evt.event_value;
        end
    end

endmodule

// ----- rtl/tset_slot_core.sv -----
// ----------------------------------------------------------------------------
// tset_slot_core
// Per-slot contact records, event update and lowest-changed-slot report.
// ----------------------------------------------------------------------------
module tset_slot_core #(
    parameter int NUM_SLOTS  = 10,
    parameter int COORD_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  tset_pkg::event_t        item,
    input  logic                    res_free,
    output logic                    advance,
    output tset_pkg::result_word_t  res
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [COORD_BITS-1:0] CMAX = '1;

    logic [SLOT_W-1:0]     cur_reg;
    logic [SLOT_W-1:0]     cur_next;
    logic [NUM_SLOTS-1:0]  active_reg;
    logic [NUM_SLOTS-1:0]  active_next;
    logic [NUM_SLOTS-1:0]  changed_reg;
    logic [NUM_SLOTS-1:0]  changed_next;
    logic [NUM_SLOTS-1:0]  down_reg;
    logic [NUM_SLOTS-1:0]  down_next;
    logic [COORD_BITS-1:0] x_reg [NUM_SLOTS];
    logic [COORD_BITS-1:0] x_next [NUM_SLOTS];
    logic [COORD_BITS-1:0] y_reg [NUM_SLOTS];
    logic [COORD_BITS-1:0] y_next [NUM_SLOTS];

    logic                  is_abs;
    logic                  is_report;
    logic                  slot_ok;
    logic [COORD_BITS-1:0] sat_val;
    logic                  found;
    logic [SLOT_W-1:0]     pick;
    logic [31:0]           pick_x;
    logic [31:0]           pick_y;

    assign advance   = item_valid && res_free;
    assign is_abs    = (item.event_type == tset_pkg::EV_TYPE_ABS);
    assign is_report = (item.event_type == tset_pkg::EV_TYPE_SYN) &&
                       (item.event_code == tset_pkg::CODE_REPORT);
    assign slot_ok   = !item.event_value[31] &&
                       ({1'b0, item.event_value[30:0]} < 32'(NUM_SLOTS));

    // clamp signed coordinate to the stored range
    always_comb
    begin
        if (item.event_value[31])
        begin
            sat_val = '0;
        end
        else if ({1'b0, item.event_value[30:0]} > 32'(CMAX))
        begin
            sat_val = CMAX;
        end
        else
        begin
            sat_val = item.event_value[COORD_BITS-1:0];
        end
    end

    // lowest changed slot
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (changed_reg[i])
            begin
                found = 1'b1;
                pick  = SLOT_W'(i);
            end
        end
    end

    assign pick_x = 32'(x_reg[pick]);
    assign pick_y = 32'(y_reg[pick]);

    always_comb
    begin
        cur_next     = cur_reg;
        active_next  = active_reg;
        changed_next = changed_reg;
        down_next    = down_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        res.valid           = 1'b0;
        res.data.touch_kind = tset_pkg::KIND_MOVE;
        res.data.touch_slot = 4'(pick);
        res.data.pos_x      = pick_x[15:0];
        res.data.pos_y      = pick_y[15:0];
        if (advance && is_abs)
        begin
            case (item.event_code)
                tset_pkg::CODE_SLOT:
                begin
                    cur_next = slot_ok ? item.event_value[SLOT_W-1:0] : '0;
                end
                tset_pkg::CODE_TRACK:
                begin
                    active_next[cur_reg]  = !item.event_value[31];
                    changed_next[cur_reg] = 1'b1;
                end
                tset_pkg::CODE_POS_X:
                begin
                    x_next[cur_reg]       = sat_val;
                    changed_next[cur_reg] = 1'b1;
                end
                tset_pkg::CODE_POS_Y:
                begin
                    y_next[cur_reg]       = sat_val;
                    changed_next[cur_reg] = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (advance && is_report && found)
        begin
            changed_next[pick] = 1'b0;
            if (active_reg[pick] && !down_reg[pick])
            begin
                res.valid           = 1'b1;
                res.data.touch_kind = tset_pkg::KIND_DOWN;
                down_next[pick]     = 1'b1;
            end
            else if (!active_reg[pick] && down_reg[pick])
            begin
                res.valid           = 1'b1;
                res.data.touch_kind = tset_pkg::KIND_UP;
                down_next[pick]     = 1'b0;
            end
            else if (active_reg[pick])
            begin
                res.valid           = 1'b1;
                res.data.touch_kind = tset_pkg::KIND_MOVE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= '0;
            active_reg  <= '0;
            changed_reg <= '0;
            down_reg    <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                x_reg[i] <= '0;
                y_reg[i] <= '0;
            end
        end
        else
        begin
            cur_reg     <= cur_next;
            active_reg  <= active_next;
            changed_reg <= changed_next;
            down_reg    <= down_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
        end
    end

endmodule

// ----- rtl/tset_out_stage.sv -----
// ----------------------------------------------------------------------------
// tset_out_stage
// Result register: holds one touch result until the receiver takes it.
// ----------------------------------------------------------------------------
module tset_out_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tset_pkg::result_word_t  res_in,
    output logic                    res_free,
    touch_result_if.source          res
);

    logic              valid_reg;
    logic              valid_next;
    tset_pkg::result_t data_reg;

    assign res_free       = !valid_reg || res.ready;
    assign res.valid      = valid_reg;
    assign res.touch_kind = data_reg.touch_kind;
    assign res.touch_slot = data_reg.touch_slot;
    assign res.pos_x      = data_reg.pos_x;
    assign res.pos_y      = data_reg.pos_y;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_free)
        begin
            valid_next = res_in.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_free && res_in.valid)
        begin
            data_reg <= res_in.data;
        end
    end

endmodule
